/* hw/rtl/etf_pkg.sv */
// shared types, constants and crc helper for the ethernet transmit framer
// no dependencies; used by every module of the framer
package etf_pkg;

    localparam int unsigned COUNT_W = 11;
    localparam logic [COUNT_W-1:0] MAX_FRAME_BYTES = 11'd1514;
    localparam logic [COUNT_W-1:0] MIN_FRAME_BYTES = 11'd14;
    localparam logic [COUNT_W-1:0] PAD_TO_BYTES    = 11'd60;

    localparam int unsigned PAD_W = 6;

    localparam logic [31:0] FCS_POLY_REFL = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [7:0]  PREAMBLE_BYTE = 8'h55;
    localparam logic [7:0]  SFD_BYTE      = 8'hD5;

    localparam int unsigned QUEUE_AW = 2;
    localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

    // what the back end does with one queued transaction
    localparam logic [1:0] OP_DATA       = 2'd0;
    localparam logic [1:0] OP_ABORT      = 2'd1;
    localparam logic [1:0] OP_DATA_ABORT = 2'd2;
    localparam logic [1:0] OP_DATA_END   = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_end;
        logic       abort_frame;
    } t_out_item;

    typedef struct packed {
        logic             sof;
        logic [1:0]       op;
        logic [7:0]       data;
        logic [PAD_W-1:0] pad_len;
    } t_cmd;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ FCS_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* hw/rtl/ethernet_tx_framer_fcs_core.sv */
// top level of the ethernet transmit framer with crc-32 fcs
// depends on etf_pkg, etf_front, etf_queue and etf_back
//
//   channel | direction | handshake             | payload
//   input   | in        | i_in_valid/o_in_stall | i_in  (data_byte, last_byte)
//   output  | out       | o_out_valid/i_out_stall | o_out (tx_byte, frame_end, abort_frame)
//
// frame data bytes leave at one per cycle in steady state when the output is not stalled;
// preamble and sfd bytes precede the first byte of a frame, (60 - length) pad bytes follow
// the last if short, then four fcs; an abort is one item; the back-end sequencer sets this
// a four-entry command queue lets the front accept bytes while the back end pads or sends fcs
// reset is synchronous and clears the counters, queue and sequencer; no clearing pass
// output stall holds the output register; the input stalls only when the queue is full
module ethernet_tx_framer_fcs_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  etf_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output etf_pkg::t_out_item o_out
);

    etf_pkg::t_cmd push_cmd, head_cmd;
    logic          push, pop, q_full, q_empty;

    etf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in),
        .i_full  (q_full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    etf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    etf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out)
    );

endmodule

/* hw/rtl/etf_front.sv */
// front end: accepts frame bytes, tracks length and drop state, classifies
// each byte it does not drop into a back-end command; depends on etf_pkg
module etf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  etf_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_push,
    output etf_pkg::t_cmd     o_cmd
);

    logic [etf_pkg::COUNT_W-1:0] r_count, n_count;
    logic                        r_dropping, n_dropping;
    logic [etf_pkg::COUNT_W-1:0] cnt1;
    logic [etf_pkg::COUNT_W-1:0] pad_full;
    logic                        accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign cnt1    = r_count + 11'd1;
    assign pad_full = etf_pkg::PAD_TO_BYTES - cnt1;

    always_comb begin
        n_count    = r_count;
        n_dropping = r_dropping;
        o_push     = 1'b0;
        o_cmd.sof     = (r_count == '0);
        o_cmd.op      = etf_pkg::OP_DATA;
        o_cmd.data    = i_item.data_byte;
        o_cmd.pad_len = '0;
        if (accept) begin
            if (r_dropping) begin
                if (i_item.last_byte) begin
                    n_dropping = 1'b0;
                    n_count    = '0;
                end
            end else begin
                o_push = 1'b1;
                if (r_count >= etf_pkg::MAX_FRAME_BYTES) begin
                    // over-long: abort now, swallow the rest of the frame
                    o_cmd.op   = etf_pkg::OP_ABORT;
                    n_count    = '0;
                    n_dropping = !i_item.last_byte;
                end else if (!i_item.last_byte) begin
                    n_count = cnt1;
                end else if (cnt1 < etf_pkg::MIN_FRAME_BYTES) begin
                    o_cmd.op = etf_pkg::OP_DATA_ABORT;
                    n_count  = '0;
                end else begin
                    o_cmd.op = etf_pkg::OP_DATA_END;
                    if (cnt1 < etf_pkg::PAD_TO_BYTES) begin
                        o_cmd.pad_len = pad_full[etf_pkg::PAD_W-1:0];
                    end
                    n_count = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_dropping <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_dropping <= n_dropping;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= etf_pkg::MAX_FRAME_BYTES)
        else $error("frame byte count beyond maximum");
    a_drop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropping |-> (r_count == '0))
        else $error("count not cleared while dropping");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("push into full queue");
`endif

endmodule

/* hw/rtl/etf_queue.sv */
// short command queue between front and back end
// depends on etf_pkg for the command type and depth
module etf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  etf_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output etf_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);

    etf_pkg::t_cmd                r_mem [etf_pkg::QUEUE_DEPTH];
    logic [etf_pkg::QUEUE_AW-1:0] r_wr, r_rd;
    logic [etf_pkg::QUEUE_AW:0]   r_fill;
    logic                         do_push, do_pop;

    assign o_full  = r_fill[etf_pkg::QUEUE_AW];
    assign o_empty = (r_fill == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/etf_back.sv */
// back end: runs queued commands, sends preamble, data, pad and fcs bytes and aborts,
// keeps the running crc and the output register; depends on etf_pkg
module etf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  etf_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output etf_pkg::t_out_item o_item
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRE  = 3'd1;
    localparam logic [2:0] S_SFD  = 3'd2;
    localparam logic [2:0] S_DATA = 3'd3;
    localparam logic [2:0] S_PAD  = 3'd4;
    localparam logic [2:0] S_FCS  = 3'd5;
    localparam logic [2:0] S_ABT  = 3'd6;

    localparam logic [2:0] PRE_LAST = 3'd6;
    localparam logic [2:0] FCS_LAST = 3'd3;

    logic [2:0]                r_state, adv_state, first_state;
    etf_pkg::t_cmd             r_cmd;
    logic [2:0]                r_idx, n_idx;
    logic [etf_pkg::PAD_W-1:0] r_pad, n_pad;
    logic [31:0]               r_crc, n_crc;
    logic [31:0]               fcs;
    logic                      r_out_valid;
    etf_pkg::t_out_item        r_out, e_item;
    logic                      can_emit, emit, done, load;

    assign can_emit = !r_out_valid || !i_stall;
    assign emit     = (r_state != S_IDLE) && can_emit;
    assign fcs      = ~r_crc;
    assign load     = ((r_state == S_IDLE) || (emit && done)) && !i_empty;
    assign o_pop    = load;
    assign o_valid  = r_out_valid;
    assign o_item   = r_out;

    always_comb begin
        if (i_cmd.sof) begin
            first_state = S_PRE;
        end else if (i_cmd.op == etf_pkg::OP_ABORT) begin
            first_state = S_ABT;
        end else begin
            first_state = S_DATA;
        end
    end

    always_comb begin
        e_item    = '0;
        done      = 1'b0;
        adv_state = r_state;
        n_idx     = r_idx;
        n_pad     = r_pad;
        n_crc     = r_crc;
        unique case (r_state)
            S_IDLE: begin
                adv_state = S_IDLE;
            end
            S_PRE: begin
                e_item.tx_byte = etf_pkg::PREAMBLE_BYTE;
                if (r_idx == PRE_LAST) begin
                    adv_state = S_SFD;
                    n_idx     = '0;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            S_SFD: begin
                e_item.tx_byte = etf_pkg::SFD_BYTE;
                adv_state = (r_cmd.op == etf_pkg::OP_ABORT) ? S_ABT : S_DATA;
            end
            S_DATA: begin
                e_item.tx_byte = r_cmd.data;
                n_crc = etf_pkg::crc_byte(r_crc, r_cmd.data);
                unique case (r_cmd.op)
                    etf_pkg::OP_DATA:       done = 1'b1;
                    etf_pkg::OP_ABORT:      done = 1'b1;
                    etf_pkg::OP_DATA_ABORT: adv_state = S_ABT;
                    etf_pkg::OP_DATA_END:   adv_state = (r_pad != '0) ? S_PAD : S_FCS;
                    default:                done = 1'b1;
                endcase
            end
            S_PAD: begin
                e_item.tx_byte = 8'd0;
                n_crc = etf_pkg::crc_byte(r_crc, 8'd0);
                n_pad = r_pad - 1'b1;
                if (r_pad == 6'd1) begin
                    adv_state = S_FCS;
                end
            end
            S_FCS: begin
                // fcs goes out least significant byte first
                e_item.tx_byte = fcs[{r_idx[1:0], 3'b000} +: 8];
                if (r_idx == FCS_LAST) begin
                    e_item.frame_end = 1'b1;
                    done = 1'b1;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            S_ABT: begin
                e_item.frame_end   = 1'b1;
                e_item.abort_frame = 1'b1;
                done = 1'b1;
            end
            default: begin
                adv_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_pad   <= '0;
            r_crc   <= etf_pkg::CRC_INIT;
        end else if (load) begin
            r_state <= first_state;
            r_idx   <= '0;
            r_pad   <= i_cmd.pad_len;
            if (i_cmd.sof) begin
                r_crc <= etf_pkg::CRC_INIT;
            end else if (emit) begin
                r_crc <= n_crc;
            end
        end else if (emit) begin
            r_state <= done ? S_IDLE : adv_state;
            r_idx   <= n_idx;
            r_pad   <= n_pad;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_emit) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= e_item;
        end
    end

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("pop from empty queue");
    a_pad_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAD) |-> (r_pad != '0))
        else $error("pad state with no pad left");
    a_fcs_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FCS) |-> (r_idx <= FCS_LAST))
        else $error("fcs byte index out of range");
    a_abort_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.abort_frame) |-> (r_out.frame_end && (r_out.tx_byte == 8'd0)))
        else $error("malformed abort transaction");
`endif

endmodule
